// ===== sv/scale_note_quantizer_macros.svh =====
// Assertion helpers for the scale note quantizer checker.
`ifndef SCALE_NOTE_QUANTIZER_MACROS_SVH
`define SCALE_NOTE_QUANTIZER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SNQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define SNQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/snq_pkg.sv =====
`timescale 1ns / 1ps

package snq_pkg;

	// fixed field widths
	localparam int NOTE_W      = 7;
	localparam int LIMIT_W     = 8;
	localparam int FRAC_W      = 16;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int OUT_IDX_W   = 6;
	localparam int CFG_INDEX_W = 2;

	// 0.999 in Q0.16, truncated
	localparam logic [FRAC_W-1:0] FRACTION_CAP = 16'd65470;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LIMIT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LIMIT = 2'd1;

	localparam logic signed [LIMIT_W-1:0] LIMIT_RESET = -8'sd1;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_LO_RD,
		S_LO_CMP,
		S_HI_RD,
		S_HI_CMP,
		S_RANGE,
		S_MUL,
		S_SEL,
		S_SEL_RD,
		S_SEL_DATA,
		S_DONE
	} state_t;

endpackage

// ===== sv/scale_note_quantizer.sv =====
`timescale 1ns / 1ps

// Scale note quantizer: ordered table of MIDI notes, queried by a Q0.16 fraction.
// Input channel (in_valid / in_stall): kind, note_in, fraction. A word is taken
// when in_valid is high and in_stall is low. in_stall stays high while a word is
// being worked on, one word at a time.
// Output channel (out_valid / out_stall): status, note_out, entry_index, one
// word per input word. The result sits in an output register; while the receiver
// stalls, the next input word is still taken and worked up to its result.
// Config channel (cfg_valid / cfg_ready): cfg_index 0 low limit, 1 high limit.
// cfg_ready is always high; write only while the block is idle.
// Append, clear and no-op go from accept straight to the done state. A query
// reads, then compares, each entry visited in each range scan (the single
// table read port is used once per visited entry, then one shared compare),
// then sizes the range, multiplies, selects and reads the chosen entry.
// The next word can be taken the cycle after the result loads.
// Reset empties the table, sets both limits to -1 and arms the limits; no
// clearing pass runs, the block is ready right after reset.
module scale_note_quantizer #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [snq_pkg::KIND_W-1:0]           kind,
	input  logic [snq_pkg::NOTE_W-1:0]           note_in,
	input  logic [snq_pkg::FRAC_W-1:0]           fraction,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [snq_pkg::STATUS_W-1:0]         status,
	output logic [snq_pkg::NOTE_W-1:0]           note_out,
	output logic [snq_pkg::OUT_IDX_W-1:0]        entry_index,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [snq_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [snq_pkg::LIMIT_W-1:0]          cfg_data
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int BKT_W  = IDX_W + 1;
	localparam int PROD_W = snq_pkg::FRAC_W + BKT_W;
	localparam int NW     = snq_pkg::NOTE_W;

	snq_pkg::state_t state_q, state_nxt;

	// control state
	logic [CNT_W-1:0]                  cnt_q;
	logic                              lim_act_q;
	logic signed [snq_pkg::LIMIT_W-1:0] low_q, high_q;
	logic                              out_valid_q;

	// working registers
	logic [IDX_W-1:0]                  scan_q, lo_q, hi_q, sel_q;
	logic [snq_pkg::FRAC_W-1:0]        frac_q;
	logic [BKT_W-1:0]                  bkt_q;
	logic [PROD_W-1:0]                 prod_q;
	logic [snq_pkg::STATUS_W-1:0]      res_status_q, out_status_q;
	logic [NW-1:0]                     res_note_q, out_note_q;
	logic [IDX_W-1:0]                  res_idx_q, out_idx_q;

	logic                              in_acc, out_free, cfg_acc;
	logic                              use_lo, use_hi, tbl_full;
	logic [IDX_W-1:0]                  last_idx;
	logic [NW-1:0]                     rd_data;
	logic [IDX_W-1:0]                  rd_addr;
	logic                              ram_we;
	logic [NW-1:0]                     cmp_a, cmp_b;
	logic                              cmp_ge;
	logic                              load_out;
	logic [BKT_W-1:0]                  sel_sum, hi_ext;
	logic [IDX_W+snq_pkg::OUT_IDX_W-1:0] idx_ext;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign in_stall = (state_q != snq_pkg::S_IDLE);

	assign use_lo   = lim_act_q && !low_q[snq_pkg::LIMIT_W-1] && (low_q != '0);
	assign use_hi   = lim_act_q && !high_q[snq_pkg::LIMIT_W-1] && (high_q != '0);
	assign tbl_full = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign ram_we   = in_acc && (kind == snq_pkg::KIND_APPEND) && !tbl_full;

	// shared magnitude compare used by both range scans
	assign cmp_ge = (cmp_a >= cmp_b);

	// bucket offset added to the low index, clamped to the high index
	assign hi_ext  = {1'b0, hi_q};
	assign sel_sum = {1'b0, lo_q} + prod_q[PROD_W-1:snq_pkg::FRAC_W];

	snq_note_ram #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (note_in),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			snq_pkg::S_IDLE: begin
				if (in_acc) begin
					if (kind == snq_pkg::KIND_QUERY && cnt_q != '0) begin
						if (use_lo) begin
							state_nxt = snq_pkg::S_LO_RD;
						end else if (use_hi) begin
							state_nxt = snq_pkg::S_HI_RD;
						end else begin
							state_nxt = snq_pkg::S_RANGE;
						end
					end else begin
						state_nxt = snq_pkg::S_DONE;
					end
				end
			end
			snq_pkg::S_LO_RD:  state_nxt = snq_pkg::S_LO_CMP;
			snq_pkg::S_LO_CMP: begin
				if (cmp_ge || scan_q == last_idx) begin
					state_nxt = use_hi ? snq_pkg::S_HI_RD : snq_pkg::S_RANGE;
				end else begin
					state_nxt = snq_pkg::S_LO_RD;
				end
			end
			snq_pkg::S_HI_RD:  state_nxt = snq_pkg::S_HI_CMP;
			snq_pkg::S_HI_CMP: begin
				if (cmp_ge || scan_q == '0) begin
					state_nxt = snq_pkg::S_RANGE;
				end else begin
					state_nxt = snq_pkg::S_HI_RD;
				end
			end
			snq_pkg::S_RANGE: begin
				state_nxt = (hi_q < lo_q) ? snq_pkg::S_DONE : snq_pkg::S_MUL;
			end
			snq_pkg::S_MUL:      state_nxt = snq_pkg::S_SEL;
			snq_pkg::S_SEL:      state_nxt = snq_pkg::S_SEL_RD;
			snq_pkg::S_SEL_RD:   state_nxt = snq_pkg::S_SEL_DATA;
			snq_pkg::S_SEL_DATA: state_nxt = snq_pkg::S_DONE;
			snq_pkg::S_DONE: begin
				if (out_free) begin
					state_nxt = snq_pkg::S_IDLE;
				end
			end
			default: state_nxt = snq_pkg::S_IDLE;
		endcase
	end

	// datapath controls per state
	always_comb begin
		rd_addr  = scan_q;
		cmp_a    = rd_data;
		cmp_b    = low_q[NW-1:0];
		load_out = 1'b0;
		case (state_q)
			snq_pkg::S_HI_CMP: begin
				cmp_a = high_q[NW-1:0];
				cmp_b = rd_data;
			end
			snq_pkg::S_SEL_RD: rd_addr = sel_q;
			snq_pkg::S_DONE:   load_out = out_free;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= snq_pkg::S_IDLE;
			cnt_q       <= '0;
			lim_act_q   <= 1'b1;
			low_q       <= snq_pkg::LIMIT_RESET;
			high_q      <= snq_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc && kind == snq_pkg::KIND_CLEAR) begin
				cnt_q <= '0;
			end else if (ram_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			// any limit write re-arms the limits; a clear disarms them
			if (cfg_acc && (cfg_index == snq_pkg::CFG_LOW_LIMIT ||
					cfg_index == snq_pkg::CFG_HIGH_LIMIT)) begin
				lim_act_q <= 1'b1;
			end else if (in_acc && kind == snq_pkg::KIND_CLEAR) begin
				lim_act_q <= 1'b0;
			end
			if (cfg_acc && cfg_index == snq_pkg::CFG_LOW_LIMIT) begin
				low_q <= cfg_data;
			end
			if (cfg_acc && cfg_index == snq_pkg::CFG_HIGH_LIMIT) begin
				high_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		case (state_q)
			snq_pkg::S_IDLE: begin
				frac_q       <= (fraction > snq_pkg::FRACTION_CAP) ?
					snq_pkg::FRACTION_CAP : fraction;
				lo_q         <= '0;
				hi_q         <= last_idx;
				scan_q       <= use_lo ? '0 : last_idx;
				if (kind == snq_pkg::KIND_APPEND) begin
					res_note_q   <= note_in;
					res_status_q <= tbl_full ? snq_pkg::STATUS_FULL : snq_pkg::STATUS_OK;
					res_idx_q    <= tbl_full ? '0 : cnt_q[IDX_W-1:0];
				end else begin
					res_note_q   <= '0;
					res_idx_q    <= '0;
					res_status_q <= (kind == snq_pkg::KIND_QUERY && cnt_q == '0) ?
						snq_pkg::STATUS_NONE : snq_pkg::STATUS_OK;
				end
			end
			snq_pkg::S_LO_CMP: begin
				lo_q <= scan_q;
				if (cmp_ge || scan_q == last_idx) begin
					scan_q <= last_idx;
				end else begin
					scan_q <= scan_q + IDX_W'(1);
				end
			end
			snq_pkg::S_HI_CMP: begin
				hi_q   <= scan_q;
				scan_q <= scan_q - IDX_W'(1);
			end
			snq_pkg::S_RANGE: begin
				bkt_q <= hi_ext - {1'b0, lo_q} + BKT_W'(1);
				if (hi_q < lo_q) begin
					res_status_q <= snq_pkg::STATUS_NONE;
				end
			end
			snq_pkg::S_MUL: begin
				prod_q <= PROD_W'(frac_q) * PROD_W'(bkt_q);
			end
			snq_pkg::S_SEL: begin
				sel_q <= (sel_sum > hi_ext) ? hi_q : sel_sum[IDX_W-1:0];
			end
			snq_pkg::S_SEL_DATA: begin
				res_note_q <= rd_data;
				res_idx_q  <= sel_q;
			end
			default: ;
		endcase
		if (load_out) begin
			out_status_q <= res_status_q;
			out_note_q   <= res_note_q;
			out_idx_q    <= res_idx_q;
		end
	end

	// report the low six bits of the table index
	assign idx_ext     = {{snq_pkg::OUT_IDX_W{1'b0}}, out_idx_q};
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign note_out    = out_note_q;
	assign entry_index = idx_ext[snq_pkg::OUT_IDX_W-1:0];

endmodule

// ===== sv/snq_note_ram.sv =====
`timescale 1ns / 1ps

// Note table storage: one write port, one registered read port.
module snq_note_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [ADDR_W-1:0]              wr_addr,
	input  logic [snq_pkg::NOTE_W-1:0]     wr_data,
	input  logic [ADDR_W-1:0]              rd_addr,
	output logic [snq_pkg::NOTE_W-1:0]     rd_data
);

	logic [snq_pkg::NOTE_W-1:0] mem_q [DEPTH];
	logic [snq_pkg::NOTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/snq_checker.sv =====
`timescale 1ns / 1ps

`include "scale_note_quantizer_macros.svh"

// Port-level checks on the quantizer.
module snq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [snq_pkg::STATUS_W-1:0]       status,
	input logic [snq_pkg::NOTE_W-1:0]         note_out,
	input logic [snq_pkg::OUT_IDX_W-1:0]      entry_index
);

	// a held result word does not change
	`SNQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(status) && $stable(note_out) && $stable(entry_index),
		"stalled result word changed")

	// one word at a time: taking a word closes the input
	`SNQ_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall,
		"input open right after a word was taken")

	// an empty range reports no note
	`SNQ_ASSERT_IMPLY(a_none_clean, clk, arst_n,
		out_valid && status == snq_pkg::STATUS_NONE,
		note_out == '0 && entry_index == '0, "no-range result carries a note")

	// a full-table append reports index zero
	`SNQ_ASSERT_IMPLY(a_full_idx, clk, arst_n,
		out_valid && status == snq_pkg::STATUS_FULL,
		entry_index == '0, "full-table result carries an index")

endmodule

bind scale_note_quantizer snq_checker u_snq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.note_out    (note_out),
	.entry_index (entry_index)
);
